// ===== rtl/core/prv_pkg.sv =====
`default_nettype none

package prv_pkg;

  localparam int unsigned MAX_PAYLOAD_BYTES_DEF = 4096;
  localparam int unsigned HEADER_BYTES_DEF      = 32;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned SIZE_W   = 13;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [WORD_W-1:0] RECORD_MAGIC = 32'h4452_5058;
  localparam logic [WORD_W-1:0] CRC_POLY     = 32'hEDB8_8320;
  localparam logic [WORD_W-1:0] CRC_PRESET   = 32'hFFFF_FFFF;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_LAYOUT_VERSION = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_SIZE   = 1'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_BAD_MAGIC   = 3'd1,
    ST_BAD_VERSION = 3'd2,
    ST_BAD_SIZE    = 3'd3,
    ST_BAD_CRC     = 3'd4
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              first_byte;
  } prv_item_t;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] computed_crc;
  } prv_result_t;

  // reflected crc-32, one byte, lsb first
  function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [WORD_W-1:0] c;
    c = crc ^ {{(WORD_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/prv_in_stage.sv =====
`default_nettype none

module prv_in_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_valid,
  output logic                    s_ready,
  input  wire prv_pkg::prv_item_t s_item,
  input  wire logic               take,
  output logic                    q_valid,
  output prv_pkg::prv_item_t      q_item
);
  import prv_pkg::*;

  // a held request leaves as a new one comes in
  assign s_ready = !q_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (s_ready) begin
      q_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      q_item <= s_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/prv_check.sv =====
`default_nettype none

module prv_check #(
  parameter int unsigned MAX_PAYLOAD_BYTES = prv_pkg::MAX_PAYLOAD_BYTES_DEF,
  parameter int unsigned HEADER_BYTES      = prv_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [prv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [prv_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  input  wire prv_pkg::prv_item_t            in_item,
  output logic                               take,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output prv_pkg::prv_result_t               out_result
);
  import prv_pkg::*;

  localparam int unsigned POS_W = $clog2(HEADER_BYTES + MAX_PAYLOAD_BYTES + 1);
  localparam int unsigned CMP_W = (POS_W > SIZE_W) ? POS_W : SIZE_W;
  localparam logic [POS_W-1:0]  HB_POS  = POS_W'(HEADER_BYTES);
  localparam logic [POS_W-1:0]  HB_LAST = POS_W'(HEADER_BYTES - 1);
  localparam logic [WORD_W-1:0] MAX_SZ  = WORD_W'(MAX_PAYLOAD_BYTES);

  logic [WORD_W-1:0] layout_version;
  logic [SIZE_W-1:0] payload_size;

  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [WORD_W-1:0] field_shift, field_shift_next;
  logic [WORD_W-1:0] stored_check, stored_check_next;
  logic [WORD_W-1:0] running_check, running_check_next;
  logic              record_done, record_done_next;

  logic              fire;
  logic              res_hit;
  prv_result_t       res;

  // state as seen by this byte, after a restart mark
  logic [POS_W-1:0]  pos_e;
  logic [WORD_W-1:0] fs_e, sc_e, rc_e;
  logic              done_e;

  assign take = !out_valid || out_ready;
  assign fire = in_valid && take;

  always_ff @(posedge clk) begin
    if (rst) begin
      layout_version <= '0;
      payload_size   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LAYOUT_VERSION: layout_version <= cfg_data;
        CFG_PAYLOAD_SIZE:   payload_size   <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (in_item.first_byte) begin
      pos_e  = '0;
      fs_e   = '0;
      sc_e   = '0;
      rc_e   = CRC_PRESET;
      done_e = 1'b0;
    end else begin
      pos_e  = byte_position;
      fs_e   = field_shift;
      sc_e   = stored_check;
      rc_e   = running_check;
      done_e = record_done;
    end
  end

  always_comb begin
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] crc_fin;
    logic [POS_W-1:0]  cnt;
    byte_position_next = byte_position;
    field_shift_next   = field_shift;
    stored_check_next  = stored_check;
    running_check_next = running_check;
    record_done_next   = record_done;
    res_hit            = 1'b0;
    res.status         = ST_OK;
    res.computed_crc   = '0;
    word    = fs_e | (WORD_W'(in_item.data_byte) << {pos_e[1:0], 3'b000});
    crc_fin = '0;
    cnt     = pos_e - HB_POS + POS_W'(1);
    if (fire) begin
      byte_position_next = pos_e;
      field_shift_next   = fs_e;
      stored_check_next  = sc_e;
      running_check_next = rc_e;
      record_done_next   = done_e;
      if (!done_e) begin
        byte_position_next = pos_e + POS_W'(1);
        if (pos_e < HB_POS) begin
          field_shift_next = word;
          if (pos_e[1:0] == 2'd3) begin
            field_shift_next = '0;
            if (pos_e[POS_W-1:2] == (POS_W-2)'(0) && word != RECORD_MAGIC) begin
              res_hit    = 1'b1;
              res.status = ST_BAD_MAGIC;
            end else if (pos_e[POS_W-1:2] == (POS_W-2)'(1) && word != layout_version) begin
              res_hit    = 1'b1;
              res.status = ST_BAD_VERSION;
            end else if (pos_e[POS_W-1:2] == (POS_W-2)'(2) &&
                         (word != WORD_W'(payload_size) ||
                          WORD_W'(payload_size) > MAX_SZ)) begin
              res_hit    = 1'b1;
              res.status = ST_BAD_SIZE;
            end else if (pos_e[POS_W-1:2] == (POS_W-2)'(3)) begin
              stored_check_next = word;
            end
          end
          // empty payload: verdict on the last header byte
          if (!res_hit && pos_e == HB_LAST && payload_size == '0) begin
            crc_fin          = ~rc_e;
            res_hit          = 1'b1;
            res.computed_crc = crc_fin;
            res.status       = (crc_fin == stored_check_next) ? ST_OK : ST_BAD_CRC;
          end
        end else begin
          running_check_next = crc_byte(rc_e, in_item.data_byte);
          if (CMP_W'(cnt) >= CMP_W'(payload_size)) begin
            crc_fin          = ~running_check_next;
            res_hit          = 1'b1;
            res.computed_crc = crc_fin;
            res.status       = (crc_fin == sc_e) ? ST_OK : ST_BAD_CRC;
          end
        end
        if (res_hit) begin
          record_done_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      field_shift   <= '0;
      stored_check  <= '0;
      running_check <= CRC_PRESET;
      record_done   <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      byte_position <= byte_position_next;
      field_shift   <= field_shift_next;
      stored_check  <= stored_check_next;
      running_check <= running_check_next;
      record_done   <= record_done_next;
      if (fire) begin
        out_valid <= res_hit;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res_hit) begin
      out_result <= res;
    end
  end

  a_result_from_request: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(fire))
    else $error("result appeared without an accepted request");

  a_header_error_zero_crc: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_result.status == ST_BAD_MAGIC ||
                   out_result.status == ST_BAD_VERSION ||
                   out_result.status == ST_BAD_SIZE))
    |-> out_result.computed_crc == '0)
    else $error("header error carries a non-zero crc");

  a_ok_matches_stored: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_result.status == ST_OK) |-> out_result.computed_crc == stored_check)
    else $error("ok result does not match the stored crc");

  a_done_after_result: assert property (@(posedge clk) disable iff (rst)
    (fire && res_hit) |=> record_done)
    else $error("record not closed after a result");

endmodule

`default_nettype wire

// ===== rtl/core/param_record_verifier.sv =====
// channel  | direction | tdata (lowest bit up)              | tuser
// s_axis   | in        | data_byte[7:0]                     | first_byte
// m_axis   | out       | status[2:0], computed_crc[34:3]    | -
// cfg      | in        | cfg_index 0 layout_version, 1 payload_size, no read-back
//
// one byte per cycle while m_axis is not stalled; an accepted byte waits in the input
// register, and the unrolled 8-bit crc step sits between the input and result registers.
// a result shows on the byte that closes the record: a failed header word, the last
// payload byte, or the last header byte when payload_size is zero.
// rst clears the pipeline and leaves the block waiting for a byte marked first_byte.
// input and output stall independently; the input register takes a new byte while
// a result waits, and the input stops only when that byte is held as well.
`default_nettype none

module param_record_verifier #(
  parameter int unsigned MAX_PAYLOAD_BYTES = prv_pkg::MAX_PAYLOAD_BYTES_DEF,
  parameter int unsigned HEADER_BYTES      = prv_pkg::HEADER_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // data_byte
  input  wire logic                          s_axis_tuser,  // first_byte
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [39:0]                        m_axis_tdata,  // status, computed_crc, zero pad
  input  wire logic                          cfg_we,
  input  wire logic [prv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [prv_pkg::CFG_W-1:0]     cfg_data
);
  import prv_pkg::*;

  prv_item_t   s_item;
  prv_item_t   q_item;
  logic        q_valid;
  logic        take;
  prv_result_t result;

  assign s_item.data_byte  = s_axis_tdata;
  assign s_item.first_byte = s_axis_tuser;

  prv_in_stage u_in_stage (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_item  (s_item),
    .take    (take),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  prv_check #(
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES),
    .HEADER_BYTES      (HEADER_BYTES)
  ) u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (q_valid),
    .in_item    (q_item),
    .take       (take),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_result (result)
  );

  assign m_axis_tdata = {5'b0_0000, result.computed_crc, result.status};

endmodule

`default_nettype wire
